[sv/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and types for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = CNT_W + 1;

  localparam int RANK_W = 20;
  localparam int ID_W   = 32;
  localparam int PREF_W = 10;
  localparam int NPREF  = 5;

  typedef struct packed {
    logic [NPREF-1:0][PREF_W-1:0] pref;
    logic [ID_W-1:0]              id;
    logic [RANK_W-1:0]            rank;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_t;

endpackage

[sv/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// mhpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of records keyed on rank, held in a single RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode 0 inserts the record given by
// in_key_rank, in_record_id and the five preference codes; opcode 1 extracts
// the record of smallest rank. Every item yields exactly one result item on
// the output channel (out_valid/out_ready) with a status and, for a good
// extract, the record taken out; all other fields are zero.
// An insert or a refused item has its result in the output register in the
// cycle after acceptance; a good extract registers its result in S_DN_LAST.
// Throughput: one item at a time. The heap walk runs S_UP_CHK and S_UP_CMP
// for each level going up and S_DN_CHK, S_DN_LEFT and, with a right child,
// S_DN_RIGHT for each level going down, all through the single read port of
// the RAM.
// Reset empties the heap at once; the RAM contents are not cleared.
// A stalled receiver holds the result in the output register; the next item
// is taken once the walk is done and the output register is free or draining.
// ----------------------------------------------------------------------------
module min_heap_priority_queue import mhpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [RANK_W-1:0] in_key_rank,
  input  logic [ID_W-1:0]   in_record_id,
  input  logic [PREF_W-1:0] in_pref_one,
  input  logic [PREF_W-1:0] in_pref_two,
  input  logic [PREF_W-1:0] in_pref_three,
  input  logic [PREF_W-1:0] in_pref_four,
  input  logic [PREF_W-1:0] in_pref_five,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [RANK_W-1:0] out_rank,
  output logic [ID_W-1:0]   out_id,
  output logic [PREF_W-1:0] out_pref_one,
  output logic [PREF_W-1:0] out_pref_two,
  output logic [PREF_W-1:0] out_pref_three,
  output logic [PREF_W-1:0] out_pref_four,
  output logic [PREF_W-1:0] out_pref_five
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_CHK   = 8'b0000_0010,
    S_UP_CMP   = 8'b0000_0100,
    S_DN_LAST  = 8'b0000_1000,
    S_DN_LOAD  = 8'b0001_0000,
    S_DN_CHK   = 8'b0010_0000,
    S_DN_LEFT  = 8'b0100_0000,
    S_DN_RIGHT = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  rec_t              item_r, item_nxt;
  rec_t              child_r, child_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  rec_t              out_rec_r, out_rec_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  rec_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rd_rec;

  logic              accept;
  logic              slot_free;
  rec_t              in_rec;
  logic [IDX_W-1:0]  left_idx, right_idx, size_idx;
  logic [ADDR_W-1:0] parent_idx;
  rec_t              pick_rec;
  logic [ADDR_W-1:0] pick_idx;

  mhpq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec    = rec_t'(ram_rdata);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign in_rec.rank    = in_key_rank;
  assign in_rec.id      = in_record_id;
  assign in_rec.pref[0] = in_pref_one;
  assign in_rec.pref[1] = in_pref_two;
  assign in_rec.pref[2] = in_pref_three;
  assign in_rec.pref[3] = in_pref_four;
  assign in_rec.pref[4] = in_pref_five;

  assign left_idx   = IDX_W'({pos_r, 1'b1});
  assign right_idx  = left_idx + IDX_W'(1);
  assign size_idx   = IDX_W'(count_r);
  assign parent_idx = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);

  // smaller child: left only if strictly less
  always_comb begin
    if (child_r.rank < rd_rec.rank) begin
      pick_rec = child_r;
      pick_idx = left_idx[ADDR_W-1:0];
    end else begin
      pick_rec = rd_rec;
      pick_idx = right_idx[ADDR_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    child_nxt      = child_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = item_r;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rec_nxt = '0;
          if (opcode_t'(in_opcode) == OP_INSERT) begin
            out_valid_nxt = 1'b1;
            if (count_r == CNT_W'(CAPACITY)) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_OK;
              item_nxt       = in_rec;
              pos_nxt        = count_r[ADDR_W-1:0];
              count_nxt      = count_r + CNT_W'(1);
              state_nxt      = S_UP_CHK;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DN_LAST;
          end
        end
      end
      S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_rec.rank > item_r.rank) begin
          ram_wdata = rd_rec;
          pos_nxt   = parent_idx;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DN_LAST: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_rec_nxt    = rd_rec;
        if (count_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = count_r[ADDR_W-1:0];
          state_nxt = S_DN_LOAD;
        end
      end
      S_DN_LOAD: begin
        item_nxt  = rd_rec;
        pos_nxt   = '0;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_idx >= size_idx) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = left_idx[ADDR_W-1:0];
          state_nxt = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        if (right_idx >= size_idx) begin
          ram_we = 1'b1;
          if (item_r.rank > rd_rec.rank) begin
            ram_wdata = rd_rec;
            pos_nxt   = left_idx[ADDR_W-1:0];
            state_nxt = S_DN_CHK;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          child_nxt = rd_rec;
          ram_raddr = right_idx[ADDR_W-1:0];
          state_nxt = S_DN_RIGHT;
        end
      end
      S_DN_RIGHT: begin
        ram_we = 1'b1;
        if (item_r.rank > pick_rec.rank) begin
          ram_wdata = pick_rec;
          pos_nxt   = pick_idx;
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_r       <= item_nxt;
    child_r      <= child_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rank       = out_rec_r.rank;
  assign out_id         = out_rec_r.id;
  assign out_pref_one   = out_rec_r.pref[0];
  assign out_pref_two   = out_rec_r.pref[1];
  assign out_pref_three = out_rec_r.pref[2];
  assign out_pref_four  = out_rec_r.pref[3];
  assign out_pref_five  = out_rec_r.pref[4];

endmodule

[verif/tb_min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue
// Self-checking bench for the min-heap priority queue: items go in through a
// valid/ready sender with random gaps, a local heap model predicts each
// result, and every result item is compared field by field as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    opcode_t op;
    rec_t    rec;
  } heap_cmd_t;

  typedef struct packed {
    status_t st;
    rec_t    rec;
  } heap_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = 1'b0;
  logic [RANK_W-1:0] in_key_rank = '0;
  logic [ID_W-1:0]   in_record_id = '0;
  logic [PREF_W-1:0] in_pref_one = '0;
  logic [PREF_W-1:0] in_pref_two = '0;
  logic [PREF_W-1:0] in_pref_three = '0;
  logic [PREF_W-1:0] in_pref_four = '0;
  logic [PREF_W-1:0] in_pref_five = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [RANK_W-1:0] out_rank;
  logic [ID_W-1:0]   out_id;
  logic [PREF_W-1:0] out_pref_one;
  logic [PREF_W-1:0] out_pref_two;
  logic [PREF_W-1:0] out_pref_three;
  logic [PREF_W-1:0] out_pref_four;
  logic [PREF_W-1:0] out_pref_five;

  rec_t      heap_mem [CAPACITY];
  int        heap_size = 0;
  heap_res_t pending_results [$];
  int        error_count = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;

  min_heap_priority_queue u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_key_rank    (in_key_rank),
    .in_record_id   (in_record_id),
    .in_pref_one    (in_pref_one),
    .in_pref_two    (in_pref_two),
    .in_pref_three  (in_pref_three),
    .in_pref_four   (in_pref_four),
    .in_pref_five   (in_pref_five),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_rank       (out_rank),
    .out_id         (out_id),
    .out_pref_one   (out_pref_one),
    .out_pref_two   (out_pref_two),
    .out_pref_three (out_pref_three),
    .out_pref_four  (out_pref_four),
    .out_pref_five  (out_pref_five)
  );

  always #5 clk = ~clk;

  // Heap model: strict compares on the way up and down, left child only if
  // strictly smaller, so equal ranks never trade places.
  task automatic heap_step(input heap_cmd_t cmd, output heap_res_t res);
    int   pos;
    int   par;
    int   lft;
    int   rgt;
    int   pick;
    rec_t tmp;
    res.st  = ST_OK;
    res.rec = '0;
    if (cmd.op == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.st = ST_FULL;
      end else begin
        pos = heap_size;
        heap_mem[pos] = cmd.rec;
        heap_size++;
        while (pos != 0) begin
          par = (pos - 1) / 2;
          if (heap_mem[par].rank <= heap_mem[pos].rank) break;
          tmp = heap_mem[par];
          heap_mem[par] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = par;
        end
      end
    end else if (heap_size == 0) begin
      res.st = ST_EMPTY;
    end else begin
      res.rec = heap_mem[0];
      heap_size--;
      heap_mem[0] = heap_mem[heap_size];
      pos = 0;
      forever begin
        lft = 2 * pos + 1;
        rgt = lft + 1;
        if (lft >= heap_size) break;
        if (rgt >= heap_size || heap_mem[lft].rank < heap_mem[rgt].rank) begin
          pick = lft;
        end else begin
          pick = rgt;
        end
        if (heap_mem[pos].rank <= heap_mem[pick].rank) break;
        tmp = heap_mem[pos];
        heap_mem[pos] = heap_mem[pick];
        heap_mem[pick] = tmp;
        pos = pick;
      end
    end
  endtask

  function automatic heap_cmd_t make_cmd(opcode_t op, int unsigned rank_max);
    heap_cmd_t cmd;
    cmd.op       = op;
    cmd.rec.rank = RANK_W'($urandom_range(rank_max));
    cmd.rec.id   = $urandom;
    for (int k = 0; k < NPREF; k++) begin
      cmd.rec.pref[k] = PREF_W'($urandom_range(999));
    end
    return cmd;
  endfunction

  task automatic send_item(input heap_cmd_t cmd);
    int        gap;
    heap_res_t res;
    gap = (!no_idle && $urandom_range(99) < 19) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= cmd.op;
    in_key_rank   <= cmd.rec.rank;
    in_record_id  <= cmd.rec.id;
    in_pref_one   <= cmd.rec.pref[0];
    in_pref_two   <= cmd.rec.pref[1];
    in_pref_three <= cmd.rec.pref[2];
    in_pref_four  <= cmd.rec.pref[3];
    in_pref_five  <= cmd.rec.pref[4];
    do @(posedge clk); while (!in_ready);
    heap_step(cmd, res);
    pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    heap_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, status", out_status, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.st) report_mismatch("status", out_status, want.st);
        if (out_rank !== want.rec.rank) report_mismatch("rank", out_rank, want.rec.rank);
        if (out_id !== want.rec.id) report_mismatch("id", out_id, want.rec.id);
        if (out_pref_one !== want.rec.pref[0])
          report_mismatch("pref_one", out_pref_one, want.rec.pref[0]);
        if (out_pref_two !== want.rec.pref[1])
          report_mismatch("pref_two", out_pref_two, want.rec.pref[1]);
        if (out_pref_three !== want.rec.pref[2])
          report_mismatch("pref_three", out_pref_three, want.rec.pref[2]);
        if (out_pref_four !== want.rec.pref[3])
          report_mismatch("pref_four", out_pref_four, want.rec.pref[3]);
        if (out_pref_five !== want.rec.pref[4])
          report_mismatch("pref_five", out_pref_five, want.rec.pref[4]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Empty extract, field extremes, a tie on the minimum and equal-rank order.
  task automatic test_edge_cases();
    heap_cmd_t cmd;
    send_item(make_cmd(OP_EXTRACT, 0));
    cmd.op = OP_INSERT;
    cmd.rec.rank = '1;
    cmd.rec.id = '1;
    for (int k = 0; k < NPREF; k++) cmd.rec.pref[k] = PREF_W'(999);
    send_item(cmd);
    cmd.rec = '0;
    send_item(cmd);
    for (int k = 1; k <= 4; k++) begin
      cmd = make_cmd(OP_INSERT, 0);
      cmd.rec.rank = RANK_W'(5);
      cmd.rec.id = k;
      send_item(cmd);
    end
    cmd = make_cmd(OP_INSERT, 0);
    cmd.rec.id = 32'ha5a5_5a5a;
    send_item(cmd);
    for (int k = 0; k < 8; k++) send_item(make_cmd(OP_EXTRACT, 0));
  endtask

  // Fill to capacity with heavy rank ties, overflow, then drain past empty.
  task automatic test_full_heap();
    for (int k = 0; k < CAPACITY + 2; k++) send_item(make_cmd(OP_INSERT, 15));
    for (int k = 0; k < CAPACITY + 1; k++) send_item(make_cmd(OP_EXTRACT, 0));
  endtask

  task automatic test_random_mix();
    int unsigned rank_max;
    int unsigned insert_pct;
    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(2))
        0: rank_max = 7;
        1: rank_max = 255;
        default: rank_max = (1 << RANK_W) - 1;
      endcase
      case (phase % 3)
        0: insert_pct = 75;
        1: insert_pct = 50;
        default: insert_pct = 30;
      endcase
      no_idle = (phase == 4);
      for (int k = 0; k < 100; k++) begin
        send_item(make_cmd(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
                           rank_max));
      end
      if (phase == 6) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_full_heap();
    test_random_mix();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
